[src/smf_pkg.sv]
package smf_pkg;

	// window geometry
	localparam int MAX_WINDOW = 16;
	localparam int DATA_W     = 32;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	// register file
	localparam int LEN_W      = 5;
	localparam int LEN_RESET  = 5;
	localparam int ADDR_W     = 3;
	localparam int APB_DATA_W = 32;

	// register index, taken from paddr[2]
	localparam logic REG_WINDOW_LEN = 1'b0;

	typedef logic signed [DATA_W-1:0] sample_t;

	// what a cell shows its neighbours
	typedef struct packed {
		sample_t          value;
		logic [IDX_W-1:0] age;
		logic             gt;        // value above the incoming sample, or cell empty
		logic             del_seen;  // evicted cell at or left of this one
	} cell_link_t;

	// broadcast to every cell
	typedef struct packed {
		logic             en;
		logic             ins;
		logic             del;
		sample_t          x;
		logic [CNT_W-1:0] held;
	} cell_ctrl_t;

endpackage

[src/smf_in_if.sv]
interface smf_in_if import smf_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

[src/smf_out_if.sv]
interface smf_out_if import smf_pkg::*; ();
	logic             valid;
	logic             ready;
	sample_t          median;
	logic [CNT_W-1:0] fill_level;

	modport source (output valid, output median, output fill_level, input ready);
	modport sink (input valid, input median, input fill_level, output ready);
endinterface

[src/smf_cfg.sv]
module smf_cfg import smf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [LEN_W-1:0]      window_len
);

	logic [LEN_W-1:0] window_len_q;
	logic             hit;

	assign pready     = 1'b1;
	assign hit        = (paddr[2] == REG_WINDOW_LEN);
	assign window_len = window_len_q;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= LEN_W'(LEN_RESET);
		end else if (psel && penable && pwrite && pready && hit) begin
			window_len_q <= pwdata[LEN_W-1:0];
		end
	end

	// readback
	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = APB_DATA_W'(window_len_q);
		end
	end

endmodule

[src/smf_cell.sv]
module smf_cell import smf_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] idx,
	input  cell_ctrl_t       ctrl,
	input  cell_link_t       left,
	input  cell_link_t       right,
	output cell_link_t       link
);

	sample_t          value_q;
	logic [IDX_W-1:0] age_q;

	logic             live;
	logic             gt_own;
	logic             d_own;
	logic             del_seen;

	// compacted view after eviction, at this slot and the one to the left
	sample_t          here_val;
	logic [IDX_W-1:0] here_age;
	logic             here_gt;
	sample_t          lft_val;
	logic [IDX_W-1:0] lft_age;
	logic             lft_gt;

	sample_t          nxt_val;
	logic [IDX_W-1:0] nxt_age;

	// local status
	always_comb begin
		live     = CNT_W'(idx) < ctrl.held;
		gt_own   = !live || (value_q > ctrl.x);
		d_own    = ctrl.del && live && (age_q == IDX_W'(ctrl.held - 1'b1));
		del_seen = left.del_seen || d_own;
	end

	assign link = '{value: value_q, age: age_q, gt: gt_own, del_seen: del_seen};

	// close the gap left by an evicted cell
	always_comb begin
		if (del_seen) begin
			here_val = right.value;
			here_age = right.age;
			here_gt  = right.gt;
		end else begin
			here_val = value_q;
			here_age = age_q;
			here_gt  = gt_own;
		end
		if (left.del_seen) begin
			lft_val = value_q;
			lft_age = age_q;
			lft_gt  = gt_own;
		end else begin
			lft_val = left.value;
			lft_age = left.age;
			lft_gt  = left.gt;
		end
	end

	// sorted insert: keep, take from the left, or take the new sample
	always_comb begin
		if (!ctrl.ins) begin
			nxt_val = here_val;
			nxt_age = here_age;
		end else if (!here_gt) begin
			nxt_val = here_val;
			nxt_age = here_age + 1'b1;
		end else if (lft_gt) begin
			nxt_val = lft_val;
			nxt_age = lft_age + 1'b1;
		end else begin
			nxt_val = ctrl.x;
			nxt_age = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			value_q <= nxt_val;
			age_q   <= nxt_age;
		end
	end

endmodule

[src/sliding_window_median_filter.sv]
// Sliding window median filter.
// samples (sink) takes one Q16.16 sample per word; results (source) returns
// one word per sample: the upper median of the samples now held and the
// fill level, 1 up to the window length.
// The samples are kept sorted in a row of MAX_WINDOW cells, each with the
// age of its sample. An accepted sample evicts the oldest one (once the
// window is full) and is inserted in order in the same cycle; every cell
// picks from itself, a neighbour or the new sample. Throughput: one sample
// per cycle unless results stalls or a shrink drains, set by the single
// insert step of the cell row. window_len is written over APB at address
// 0; the user must write it only while the block is idle, which the block
// does not enforce. A shrink below the fill level evicts the oldest samples
// one per cycle while no result is pending, before a new sample is taken.
// Reset clears the fill level, the result register and sets window_len to 5.
// When results is stalled, one result waits in the output register and one
// more is held in the cell row; samples.ready then drops until it drains.
module sliding_window_median_filter import smf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	smf_in_if.sink                samples,
	smf_out_if.source             results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam cell_link_t LEFT_EDGE  = '{value: '0, age: '0, gt: 1'b0, del_seen: 1'b0};
	localparam cell_link_t RIGHT_EDGE = '{value: '0, age: '0, gt: 1'b1, del_seen: 1'b0};

	logic [LEN_W-1:0] window_len;
	logic [CNT_W-1:0] len_eff;
	logic [CNT_W-1:0] held_q;
	logic             pend_q;
	logic             out_valid_q;
	sample_t          median_q;
	logic [CNT_W-1:0] fill_q;

	logic             shrink;
	logic             can_load;
	logic             load;
	logic             accept;
	logic             evict;
	cell_ctrl_t       ctrl;
	cell_link_t       link [MAX_WINDOW];

	smf_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.window_len (window_len)
	);

	// clamp the window length into 1..MAX_WINDOW
	always_comb begin
		if (window_len == '0) begin
			len_eff = CNT_W'(1);
		end else if (32'(window_len) > MAX_WINDOW) begin
			len_eff = CNT_W'(MAX_WINDOW);
		end else begin
			len_eff = CNT_W'(window_len);
		end
	end

	// handshake and cell row control
	always_comb begin
		shrink        = held_q > len_eff;
		can_load      = !out_valid_q || results.ready;
		load          = pend_q && can_load;
		samples.ready = !shrink && (!pend_q || can_load);
		accept        = samples.valid && samples.ready;
		evict         = shrink && !pend_q;
		ctrl.en       = accept || evict;
		ctrl.ins      = accept;
		ctrl.del      = accept ? (held_q >= len_eff) : evict;
		ctrl.x        = samples.sample;
		ctrl.held     = held_q;
	end

	// cell row
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		cell_link_t lnk_l;
		cell_link_t lnk_r;
		if (i == 0) begin : g_l_edge
			assign lnk_l = LEFT_EDGE;
		end else begin : g_l_mid
			assign lnk_l = link[i-1];
		end
		if (i == MAX_WINDOW - 1) begin : g_r_edge
			assign lnk_r = RIGHT_EDGE;
		end else begin : g_r_mid
			assign lnk_r = link[i+1];
		end
		smf_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(i)),
			.ctrl  (ctrl),
			.left  (lnk_l),
			.right (lnk_r),
			.link  (link[i])
		);
	end

	// fill level and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (accept) begin
				held_q <= ctrl.del ? held_q : held_q + 1'b1;
			end else if (evict) begin
				held_q <= held_q - 1'b1;
			end
			if (accept) begin
				pend_q <= 1'b1;
			end else if (load) begin
				pend_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			median_q <= link[IDX_W'(held_q >> 1)].value;
			fill_q   <= held_q;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.median     = median_q;
	assign results.fill_level = fill_q;

	// no sample taken while a shrink is still draining
	a_no_accept_on_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (held_q <= len_eff))
		else $error("sample accepted above window length");

	// fill level stays within the cell row
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(held_q) <= MAX_WINDOW)
		else $error("fill level beyond cell count");

	// an accepted sample leaves a pending result
	a_accept_pend: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pend_q)
		else $error("accepted sample lost");

	// a result never reports an empty window
	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.fill_level != '0))
		else $error("result with empty window");

endmodule
